// File: rtl/sras_pkg.sv
// Package with the shared types and constants of the SPI register access sequencer.
package sras_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = 6;
    localparam int POS_W        = 5;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [7:0] ADDR_READ_FLAG = 8'h80;
    localparam logic [7:0] ADDR_WRITE_MASK = 8'h7F;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Register index as taken from paddr[2].
    localparam logic REG_DUMMY_BYTE = 1'b0;

    typedef enum logic [2:0] {
        ACT_LOAD     = 3'd0,
        ACT_START_RD = 3'd1,
        ACT_START_WR = 3'd2,
        ACT_TX_READY = 3'd3,
        ACT_RX_BYTE  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RCMD  = 3'd1,
        PH_WCMD  = 3'd2,
        PH_WDATA = 3'd3,
        PH_RDATA = 3'd4
    } t_phase;

    typedef struct packed {
        logic [2:0]       action;
        logic [7:0]       reg_addr;
        logic [CNT_W-1:0] xfer_count;
        logic [4:0]       buf_index;
        logic [7:0]       byte_value;
    } t_in_word;

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             rx_valid;
        logic [7:0]       rx_data;
        logic [POS_W-1:0] rx_position;
        logic             select_active;
        logic             done_res;
        logic             rejected;
        logic [2:0]       phase;
    } t_out_word;

    // Handshake between the input register and the sequencer core.
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_in_stage;

endpackage

// File: rtl/sras_in_if.sv
// Input channel of the sequencer: event words with valid/ready handshake.
interface sras_in_if;
    import sras_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       action;
    logic [7:0]       reg_addr;
    logic [CNT_W-1:0] xfer_count;
    logic [4:0]       buf_index;
    logic [7:0]       byte_value;

    modport source (
        output valid, action, reg_addr, xfer_count, buf_index, byte_value,
        input  ready
    );
    modport sink (
        input  valid, action, reg_addr, xfer_count, buf_index, byte_value,
        output ready
    );
endinterface

// File: rtl/sras_out_if.sv
// Output channel of the sequencer: result words with valid/ready handshake.
interface sras_out_if;
    import sras_pkg::*;

    logic             valid;
    logic             ready;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             rx_valid;
    logic [7:0]       rx_data;
    logic [POS_W-1:0] rx_position;
    logic             select_active;
    logic             done_res;
    logic             rejected;
    logic [2:0]       phase;

    modport source (
        output valid, tx_valid, tx_byte, rx_valid, rx_data, rx_position,
               select_active, done_res, rejected, phase,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, rx_valid, rx_data, rx_position,
               select_active, done_res, rejected, phase,
        output ready
    );
endinterface

// File: rtl/sras_cfg.sv
// APB-style configuration register block holding the dummy byte.
module sras_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sras_pkg::APB_AW-1:0] paddr,
    input  logic [sras_pkg::APB_DW-1:0] pwdata,
    output logic [sras_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [7:0]                 o_dummy_byte
);
    import sras_pkg::*;

    logic [7:0] r_dummy_byte;
    logic       reg_index;
    logic       wr_en;

    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dummy_byte <= BYTE_ZERO;
        end else if (wr_en && (reg_index == REG_DUMMY_BYTE)) begin
            r_dummy_byte <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_DUMMY_BYTE) begin
            prdata = {{(APB_DW-8){1'b0}}, r_dummy_byte};
        end
    end

    assign o_dummy_byte = r_dummy_byte;

endmodule

// File: rtl/sras_in_reg.sv
// Input register that captures one event word and holds it until the core takes it.
module sras_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sras_in_if.sink              i_in,
    input  logic                 i_take,
    output sras_pkg::t_in_stage  o_stage
);
    import sras_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.action     <= i_in.action;
            r_word.reg_addr   <= i_in.reg_addr;
            r_word.xfer_count <= i_in.xfer_count;
            r_word.buf_index  <= i_in.buf_index;
            r_word.byte_value <= i_in.byte_value;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

// File: rtl/sras_seq.sv
// Sequencer core: phase machine, write buffer, counters and the result register.
module sras_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sras_pkg::t_in_stage  i_stage,
    input  logic [7:0]           i_dummy_byte,
    output logic                 o_take,
    sras_out_if.source           o_out
);
    import sras_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_tx_rem, n_tx_rem;
    logic [CNT_W-1:0] r_rx_rem, n_rx_rem;
    logic [BUF_AW-1:0] r_tx_ptr, n_tx_ptr;
    logic [POS_W-1:0] r_rx_ptr, n_rx_ptr;
    logic [7:0]       r_buf [BUFFER_DEPTH];
    logic             r_out_valid;
    t_out_word        r_out, n_out;

    t_in_word         word;
    logic             busy;
    logic [CNT_W-1:0] count_sat;
    logic [7:0]       buf_rd;
    logic             buf_we;
    logic             advance;

    assign word    = i_stage.word;
    assign busy    = (r_phase != PH_IDLE);
    assign advance = i_stage.valid && (!r_out_valid || o_out.ready);
    assign o_take  = advance;

    assign count_sat = (int'(word.xfer_count) > BUFFER_DEPTH) ?
                       CNT_W'(BUFFER_DEPTH) : word.xfer_count;

    assign buf_rd = (int'(r_tx_ptr) < BUFFER_DEPTH) ? r_buf[r_tx_ptr] : BYTE_ZERO;

    assign buf_we = (word.action == ACT_LOAD) && !busy &&
                    (int'(word.buf_index) < BUFFER_DEPTH);

    // Next state of the phase machine and its counters.
    always_comb begin
        n_phase  = r_phase;
        n_tx_rem = r_tx_rem;
        n_rx_rem = r_rx_rem;
        n_tx_ptr = r_tx_ptr;
        n_rx_ptr = r_rx_ptr;
        case (word.action)
            ACT_START_RD, ACT_START_WR: begin
                if (!busy) begin
                    n_phase  = (word.action == ACT_START_RD) ? PH_RCMD : PH_WCMD;
                    n_tx_rem = count_sat;
                    n_rx_rem = count_sat;
                    n_tx_ptr = '0;
                    n_rx_ptr = '0;
                end
            end
            ACT_TX_READY: begin
                if (r_phase == PH_RCMD || r_phase == PH_RDATA) begin
                    if (r_tx_rem != '0) begin
                        n_tx_rem = r_tx_rem - 1'b1;
                    end
                end else if (r_phase == PH_WCMD || r_phase == PH_WDATA) begin
                    if (r_tx_rem != '0) begin
                        n_phase  = PH_WDATA;
                        n_tx_ptr = r_tx_ptr + 1'b1;
                        n_tx_rem = r_tx_rem - 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            ACT_RX_BYTE: begin
                if (r_phase == PH_RCMD) begin
                    n_phase = (r_rx_rem == '0) ? PH_IDLE : PH_RDATA;
                end else if (r_phase == PH_RDATA) begin
                    if (r_rx_rem != '0) begin
                        n_rx_ptr = r_rx_ptr + 1'b1;
                        n_rx_rem = r_rx_rem - 1'b1;
                    end
                    // The last data byte, or none left at all, closes the read.
                    if (r_rx_rem <= CNT_W'(1)) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result word for the current event.
    always_comb begin
        n_out               = '0;
        n_out.phase         = n_phase;
        n_out.select_active = (n_phase != PH_IDLE);
        case (word.action)
            ACT_LOAD: begin
                n_out.rejected = busy;
            end
            ACT_START_RD: begin
                n_out.rejected = busy;
                if (!busy) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = word.reg_addr | ADDR_READ_FLAG;
                end
            end
            ACT_START_WR: begin
                n_out.rejected = busy;
                if (!busy) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = word.reg_addr & ADDR_WRITE_MASK;
                end
            end
            ACT_TX_READY: begin
                if (r_tx_rem != '0) begin
                    if (r_phase == PH_RCMD || r_phase == PH_RDATA) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = i_dummy_byte;
                    end else if (r_phase == PH_WCMD || r_phase == PH_WDATA) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = buf_rd;
                    end
                end else if (r_phase == PH_WCMD || r_phase == PH_WDATA) begin
                    n_out.done_res = 1'b1;
                end
            end
            ACT_RX_BYTE: begin
                if (r_phase == PH_RCMD) begin
                    n_out.done_res = (r_rx_rem == '0);
                end else if (r_phase == PH_RDATA) begin
                    if (r_rx_rem != '0) begin
                        n_out.rx_valid    = 1'b1;
                        n_out.rx_data     = word.byte_value;
                        n_out.rx_position = r_rx_ptr;
                    end
                    n_out.done_res = (r_rx_rem <= CNT_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tx_rem    <= '0;
            r_rx_rem    <= '0;
            r_tx_ptr    <= '0;
            r_rx_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase  <= n_phase;
                r_tx_rem <= n_tx_rem;
                r_rx_rem <= n_rx_rem;
                r_tx_ptr <= n_tx_ptr;
                r_rx_ptr <= n_rx_ptr;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && buf_we) begin
            r_buf[BUF_AW'(word.buf_index)] <= word.byte_value;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tx_valid      = r_out.tx_valid;
    assign o_out.tx_byte       = r_out.tx_byte;
    assign o_out.rx_valid      = r_out.rx_valid;
    assign o_out.rx_data       = r_out.rx_data;
    assign o_out.rx_position   = r_out.rx_position;
    assign o_out.select_active = r_out.select_active;
    assign o_out.done_res      = r_out.done_res;
    assign o_out.rejected      = r_out.rejected;
    assign o_out.phase         = r_out.phase;

endmodule

// File: rtl/spi_register_access_sequencer.sv
// SPI register access sequencer, controller side: one event word in, one result word out.
// The block takes one event word per cycle while the output is not stalled, and returns
// one result word for each, in order. A word is held in the input register and then moves
// through the phase logic into the result register, from which its result is offered; the
// phase update and the write buffer read mux set the rate of one word per clock. A stalled
// output holds its result word while one more event word waits in the input register.
// Write data is loaded while idle; a start sends the command byte, each transmit-ready
// sends the next data or dummy byte, and read bytes come back numbered.
// The 32-entry write buffer has no reset: sending an entry that was never loaded gives
// an arbitrary byte. The dummy byte register sits at byte address 0 of the APB port.
module spi_register_access_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sras_in_if.sink                     i_in,
    sras_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sras_pkg::APB_AW-1:0] paddr,
    input  logic [sras_pkg::APB_DW-1:0] pwdata,
    output logic [sras_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import sras_pkg::*;

    logic       dummy_byte;
    logic [7:0] dummy_val;
    t_in_stage  stage;
    logic       take;

    assign dummy_byte = 1'b0;

    sras_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_dummy_byte (dummy_val)
    );

    sras_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    sras_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (stage),
        .i_dummy_byte (dummy_val | {7'b0, dummy_byte}),
        .o_take       (take),
        .o_out        (o_out)
    );

endmodule

// File: rtl/sras_checker.sv
// Port-level checker for the SPI register access sequencer, with its bind statement.
module sras_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_tx_valid,
    input logic       i_rx_valid,
    input logic       i_select_active,
    input logic       i_done_res,
    input logic       i_rejected,
    input logic [2:0] i_phase
);
    import sras_pkg::*;

    // Select follows the phase that the word leaves behind.
    a_select_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_select_active == (i_phase != PH_IDLE)))
        else $error("select_active disagrees with phase");

    // A finishing word always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done_res) |-> (i_phase == PH_IDLE))
        else $error("done_res without return to idle");

    // Read data only appears in the read data phase or on its closing word.
    a_rx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_rx_valid) |-> ((i_phase == PH_RDATA) || i_done_res))
        else $error("rx_valid outside a read transfer");

    // A rejected word has no other effect.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_rejected) |-> (!i_tx_valid && !i_rx_valid && !i_done_res))
        else $error("rejected word caused activity");

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word withdrawn while stalled");

endmodule

bind spi_register_access_sequencer sras_checker u_sras_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_tx_valid      (o_out.tx_valid),
    .i_rx_valid      (o_out.rx_valid),
    .i_select_active (o_out.select_active),
    .i_done_res      (o_out.done_res),
    .i_rejected      (o_out.rejected),
    .i_phase         (o_out.phase)
);

// File: tb/sv/sras_sequencer_checker.sv
// Checker for the SPI register access sequencer: predicts each result word and compares it.
module sras_sequencer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sras_in_if                          in_mon,
    sras_out_if                         out_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sras_pkg::APB_AW-1:0] paddr,
    input  logic [sras_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          o_fail_count
);
    import sras_pkg::*;

    t_phase             seq_phase;
    logic [CNT_W-1:0]   tx_left;
    logic [CNT_W-1:0]   rx_left;
    logic [BUF_AW-1:0]  tx_ptr;
    logic [POS_W-1:0]   rx_ptr;
    logic [7:0]         byte_store [BUFFER_DEPTH];
    logic [7:0]         dummy_fill;

    t_out_word          awaited_words [$];
    int                 error_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = error_count + pending_count;

    // Applies one event word to the shadow sequencer and returns the result it must produce.
    function automatic t_out_word sequencer_result(input t_in_word w);
        t_out_word  r;
        logic       busy;
        logic [CNT_W-1:0] count;
        r = '0;
        busy = (seq_phase != PH_IDLE);
        case (w.action)
            ACT_LOAD: begin
                if (busy)
                    r.rejected = 1'b1;
                else if (int'(w.buf_index) < BUFFER_DEPTH)
                    byte_store[w.buf_index] = w.byte_value;
            end
            ACT_START_RD, ACT_START_WR: begin
                if (busy) begin
                    r.rejected = 1'b1;
                end else begin
                    count = (w.xfer_count > CNT_W'(BUFFER_DEPTH)) ? CNT_W'(BUFFER_DEPTH)
                                                                 : w.xfer_count;
                    tx_left = count;
                    rx_left = count;
                    tx_ptr = '0;
                    rx_ptr = '0;
                    r.tx_valid = 1'b1;
                    if (w.action == ACT_START_RD) begin
                        seq_phase = PH_RCMD;
                        r.tx_byte = w.reg_addr | ADDR_READ_FLAG;
                    end else begin
                        seq_phase = PH_WCMD;
                        r.tx_byte = w.reg_addr & ADDR_WRITE_MASK;
                    end
                end
            end
            ACT_TX_READY: begin
                if (seq_phase == PH_RCMD || seq_phase == PH_RDATA) begin
                    if (tx_left != 0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = dummy_fill;
                        tx_left--;
                    end
                end else if (seq_phase == PH_WCMD || seq_phase == PH_WDATA) begin
                    seq_phase = PH_WDATA;
                    if (tx_left != 0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = byte_store[tx_ptr];
                        tx_ptr++;
                        tx_left--;
                    end else begin
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            ACT_RX_BYTE: begin
                if (seq_phase == PH_RCMD) begin
                    // The byte clocked in during the command is never delivered.
                    if (rx_left == 0) begin
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end else begin
                        seq_phase = PH_RDATA;
                    end
                end else if (seq_phase == PH_RDATA) begin
                    if (rx_left != 0) begin
                        r.rx_valid = 1'b1;
                        r.rx_data = w.byte_value;
                        r.rx_position = rx_ptr;
                        rx_ptr++;
                        rx_left--;
                    end
                    if (rx_left == 0) begin
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.select_active = (seq_phase != PH_IDLE);
        r.phase = seq_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_in_word  w;
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            seq_phase = PH_IDLE;
            tx_left = '0;
            rx_left = '0;
            tx_ptr = '0;
            rx_ptr = '0;
            dummy_fill = BYTE_ZERO;
            awaited_words.delete();
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_DUMMY_BYTE)
                dummy_fill = pwdata[7:0];

            if (out_mon.valid && out_mon.ready) begin
                got.tx_valid      = out_mon.tx_valid;
                got.tx_byte       = out_mon.tx_byte;
                got.rx_valid      = out_mon.rx_valid;
                got.rx_data       = out_mon.rx_data;
                got.rx_position   = out_mon.rx_position;
                got.select_active = out_mon.select_active;
                got.done_res      = out_mon.done_res;
                got.rejected      = out_mon.rejected;
                got.phase         = out_mon.phase;
                if (awaited_words.size() == 0) begin
                    $error("result word with no event word waiting for it");
                    error_count++;
                end else begin
                    want = awaited_words.pop_front();
                    pending_count--;
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("rx_valid", want.rx_valid, got.rx_valid);
                    check_field("rx_data", want.rx_data, got.rx_data);
                    check_field("rx_position", want.rx_position, got.rx_position);
                    check_field("select_active", want.select_active, got.select_active);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("rejected", want.rejected, got.rejected);
                    check_field("phase", want.phase, got.phase);
                end
            end

            if (in_mon.valid && in_mon.ready) begin
                w.action     = in_mon.action;
                w.reg_addr   = in_mon.reg_addr;
                w.xfer_count = in_mon.xfer_count;
                w.buf_index  = in_mon.buf_index;
                w.byte_value = in_mon.byte_value;
                awaited_words.push_back(sequencer_result(w));
                pending_count++;
            end
        end
    end

endmodule

// File: tb/sv/spi_register_access_sequencer_test.sv
// Top of the sequencer testbench: clock, reset, event and register stimulus, verdict.
module spi_register_access_sequencer_test;
    import sras_pkg::*;

    localparam logic [2:0]        ACT_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]        ACT_LAST_UNUSED  = 3'd7;
    localparam logic [APB_AW-1:0] DUMMY_BYTE_ADDR  = APB_AW'(4 * REG_DUMMY_BYTE);
    localparam int                STALL_LIMIT      = 2000;
    localparam int                PHASE_WORDS      = 510;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sras_in_if  in_ch ();
    sras_out_if out_ch ();

    int                      fail_count;
    int                      words_sent = 0;
    int                      results_taken = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      stall_cycles_req = 0;
    logic [BUFFER_DEPTH-1:0] entry_loaded = '0;

    spi_register_access_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sras_sequencer_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_cycles_req != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall_cycles_req) @(posedge i_clk);
                stall_cycles_req = 0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            results_taken <= results_taken + 1;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_in_word random_word(input logic [2:0] act);
        t_in_word w;
        w.action     = act;
        w.reg_addr   = 8'($urandom);
        w.xfer_count = CNT_W'($urandom);
        w.buf_index  = 5'($urandom);
        w.byte_value = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= w.action;
        in_ch.reg_addr   <= w.reg_addr;
        in_ch.xfer_count <= w.xfer_count;
        in_ch.buf_index  <= w.buf_index;
        in_ch.byte_value <= w.byte_value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        words_sent++;
    endtask

    // Only called while the sequencer is known to be idle, so the load always lands.
    task automatic load_entry(input logic [4:0] idx, input logic [7:0] value);
        t_in_word w;
        w = random_word(ACT_LOAD);
        w.buf_index = idx;
        w.byte_value = value;
        send_word(w);
        entry_loaded[idx] = 1'b1;
    endtask

    // Words that a busy sequencer must reject or ignore.
    task automatic send_busy_noise();
        case ($urandom_range(3))
            0: send_word(random_word(ACT_LOAD));
            1: send_word(random_word(ACT_START_RD));
            2: send_word(random_word(ACT_START_WR));
            default: send_word(random_word(3'($urandom_range(ACT_LAST_UNUSED,
                                                              ACT_FIRST_UNUSED))));
        endcase
    endtask

    task automatic write_transfer(input logic [CNT_W-1:0] count);
        int       eff;
        int       left;
        int       pick;
        t_in_word w;
        eff = (count > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(count);
        for (int i = 0; i < eff; i++)
            if (!entry_loaded[i])
                load_entry(5'(i), 8'($urandom));
        repeat ($urandom_range(2)) load_entry(5'($urandom), 8'($urandom));
        w = random_word(ACT_START_WR);
        w.xfer_count = count;
        send_word(w);
        // One transmit-ready per data byte, and one more to close the transfer.
        left = eff + 1;
        while (left > 0) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                send_word(random_word(ACT_TX_READY));
                left--;
            end else if (pick < 8) begin
                send_word(random_word(ACT_RX_BYTE));
            end else begin
                send_busy_noise();
            end
        end
    endtask

    task automatic read_transfer(input logic [CNT_W-1:0] count);
        int       eff;
        int       left;
        int       pick;
        t_in_word w;
        eff = (count > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(count);
        w = random_word(ACT_START_RD);
        w.xfer_count = count;
        send_word(w);
        // The command byte comes back first, then one byte per data position.
        left = eff + 1;
        while (left > 0) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                send_word(random_word(ACT_TX_READY));
            end else if (pick < 8) begin
                send_word(random_word(ACT_RX_BYTE));
                left--;
            end else begin
                send_busy_noise();
            end
        end
    endtask

    task automatic wait_drained();
        wait (results_taken == words_sent);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_dummy_byte(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DUMMY_BYTE_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase(input int n_words);
        int               first;
        int               pick;
        int               size_roll;
        logic [CNT_W-1:0] count;
        first = words_sent;
        while (words_sent - first < n_words) begin
            pick = $urandom_range(99);
            if (pick < 88) begin
                // Mostly short transfers; a few long ones and a few oversized counts.
                size_roll = $urandom_range(99);
                if (size_roll < 85)
                    count = CNT_W'($urandom_range(6));
                else if (size_roll < 95)
                    count = CNT_W'($urandom_range(BUFFER_DEPTH, 7));
                else
                    count = CNT_W'($urandom_range(63, BUFFER_DEPTH + 1));
                if (pick < 44)
                    write_transfer(count);
                else
                    read_transfer(count);
            end else begin
                case ($urandom_range(3))
                    0: send_word(random_word(ACT_TX_READY));
                    1: send_word(random_word(ACT_RX_BYTE));
                    2: send_word(random_word(3'($urandom_range(ACT_LAST_UNUSED,
                                                                ACT_FIRST_UNUSED))));
                    default: load_entry(5'($urandom), 8'($urandom));
                endcase
            end
        end
        in_ch.valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        t_in_word w;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_LOAD;
        in_ch.reg_addr   <= '0;
        in_ch.xfer_count <= '0;
        in_ch.buf_index  <= '0;
        in_ch.byte_value <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        write_dummy_byte(8'h00);
        load_entry(5'd0, 8'h00);
        load_entry(5'd31, 8'hFF);
        load_entry(5'd1, 8'hA5);
        send_word(random_word(ACT_TX_READY));
        send_word(random_word(ACT_RX_BYTE));
        send_word(random_word(ACT_LAST_UNUSED));

        w = random_word(ACT_START_WR);
        w.reg_addr = 8'hFF;
        w.xfer_count = CNT_W'(2);
        send_word(w);
        send_word(random_word(ACT_TX_READY));
        send_word(random_word(ACT_RX_BYTE));
        send_word(random_word(ACT_TX_READY));
        send_word(random_word(ACT_LOAD));
        send_word(random_word(ACT_START_RD));
        send_word(random_word(ACT_TX_READY));

        w = random_word(ACT_START_RD);
        w.reg_addr = 8'h00;
        w.xfer_count = '0;
        send_word(w);
        send_word(random_word(ACT_RX_BYTE));

        w = random_word(ACT_START_WR);
        w.xfer_count = '0;
        send_word(w);
        send_word(random_word(ACT_TX_READY));

        // Second transmit-ready finds no dummy bytes left to send.
        w = random_word(ACT_START_RD);
        w.reg_addr = 8'h00;
        w.xfer_count = CNT_W'(1);
        send_word(w);
        send_word(random_word(ACT_TX_READY));
        send_word(random_word(ACT_TX_READY));
        send_word(random_word(ACT_RX_BYTE));
        w = random_word(ACT_RX_BYTE);
        w.byte_value = 8'hFF;
        send_word(w);
        in_ch.valid <= 1'b0;
        wait_drained();

        write_dummy_byte(8'hFF);
        send_idle_pct = 6;
        recv_idle_pct = 71;
        random_phase(PHASE_WORDS);

        write_dummy_byte(8'($urandom));
        send_idle_pct = 71;
        recv_idle_pct = 6;
        random_phase(PHASE_WORDS);

        write_dummy_byte(8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_cycles_req = 80;
        random_phase(PHASE_WORDS);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
